>>> rtl/sol_pkg.sv
// ----------------------------------------------------------------------------
// sol_pkg: shared types and constants of the sorted offset lookup table
// Request and status codes, table sizing, the stored entry and the FSM states.
// ----------------------------------------------------------------------------
package sol_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int POS_W       = IDX_W + 1;
  localparam int OFF_W       = 64;
  localparam int ID_W        = 10;
  localparam int CNT_W       = 11;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_COUNT = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_LOCKED = 2'd1,
    STAT_FULL   = 2'd2
  } stat_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP
  } state_t;

endpackage

>>> rtl/sol_ram.sv
// ----------------------------------------------------------------------------
// sol_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sorted_offset_lookup_table.sv
// ----------------------------------------------------------------------------
// sorted_offset_lookup_table: sorted table of 64-bit offsets with find/count
// Load: an insertion walk from the top shifts larger entries up one slot until
//   the new entry's slot is found; each RAM probe has a read and a compare state.
// Find: one binary search of at most 11 probes for 1024 entries.
// Count: two binary searches, one per bound. Rejects/no-ops answer from idle.
// One request at a time; the next is taken in the done cycle. Results cannot
// be stalled. Sync reset clears the count and the lock, not the table RAM.
// ----------------------------------------------------------------------------
module sorted_offset_lookup_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic [sol_pkg::OFF_W-1:0] address,
  input  logic [sol_pkg::OFF_W-1:0] length,
  output logic                      done,
  output logic [1:0]                status,
  output logic                      found,
  output logic [sol_pkg::ID_W-1:0]  entry_id,
  output logic [sol_pkg::CNT_W-1:0] match_count,
  output logic [sol_pkg::CNT_W-1:0] entry_count
);

  sol_pkg::state_t state, state_next;
  logic [sol_pkg::POS_W-1:0] cnt, cnt_next;
  logic indexed, indexed_next;
  logic done_next;
  logic [sol_pkg::POS_W-1:0] lo, lo_next, hi, hi_next, b_pos, b_pos_next;
  logic [sol_pkg::POS_W-1:0] j, j_next;
  logic [sol_pkg::OFF_W-1:0] key, key_next, end_key, end_key_next;
  logic [1:0] req_q, req_q_next;
  logic second, second_next;
  sol_pkg::entry_t hit, hit_next;
  logic [1:0] status_next;
  logic found_next;
  logic [sol_pkg::ID_W-1:0] id_next;
  logic [sol_pkg::CNT_W-1:0] match_next;

  logic [sol_pkg::POS_W-1:0] mid;
  logic we, re;
  logic [sol_pkg::IDX_W-1:0] waddr, raddr;
  sol_pkg::entry_t wdata, rdata;
  sol_pkg::entry_t new_ent;

  sol_ram #(
    .WIDTH(sol_pkg::ENTRY_W),
    .DEPTH(sol_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy        = (state != sol_pkg::ST_IDLE);
  assign entry_count = sol_pkg::CNT_W'(cnt);
  assign mid         = lo + ((hi - lo) >> 1);
  assign new_ent.offset = key;
  assign new_ent.id     = cnt[sol_pkg::ID_W-1:0];

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sol_pkg::ST_IDLE;
      cnt     <= '0;
      indexed <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      indexed <= indexed_next;
      done    <= done_next;
    end
    lo          <= lo_next;
    hi          <= hi_next;
    b_pos       <= b_pos_next;
    j           <= j_next;
    key         <= key_next;
    end_key     <= end_key_next;
    req_q       <= req_q_next;
    second      <= second_next;
    hit         <= hit_next;
    status      <= status_next;
    found       <= found_next;
    entry_id    <= id_next;
    match_count <= match_next;
  end

  // sequence requests: insertion walk for loads, binary search for queries
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    indexed_next = indexed;
    done_next    = 1'b0;
    lo_next      = lo;
    hi_next      = hi;
    b_pos_next   = b_pos;
    j_next       = j;
    key_next     = key;
    end_key_next = end_key;
    req_q_next   = req_q;
    second_next  = second;
    hit_next     = hit;
    status_next  = status;
    found_next   = found;
    id_next      = entry_id;
    match_next   = match_count;
    we    = 1'b0;
    re    = 1'b0;
    waddr = j[sol_pkg::IDX_W-1:0];
    wdata = new_ent;
    raddr = mid[sol_pkg::IDX_W-1:0];
    case (state)
      sol_pkg::ST_IDLE: begin
        if (start) begin
          req_q_next   = req_type;
          key_next     = address;
          end_key_next = address + length;
          lo_next      = '0;
          hi_next      = cnt;
          j_next       = cnt;
          second_next  = 1'b0;
          status_next  = sol_pkg::STAT_OK;
          found_next   = 1'b0;
          id_next      = '0;
          match_next   = '0;
          case (req_type)
            sol_pkg::REQ_LOAD: begin
              if (indexed) begin
                status_next = sol_pkg::STAT_LOCKED;
                done_next   = 1'b1;
              end else if (cnt >= sol_pkg::POS_W'(sol_pkg::MAX_ENTRIES)) begin
                status_next = sol_pkg::STAT_FULL;
                done_next   = 1'b1;
              end else begin
                state_next = sol_pkg::ST_INS_RD;
              end
            end
            sol_pkg::REQ_FIND, sol_pkg::REQ_COUNT: begin
              indexed_next = 1'b1;
              state_next   = sol_pkg::ST_SRCH_RD;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      sol_pkg::ST_INS_RD: begin
        // place the new entry at slot zero, or fetch the neighbor below
        if (j == '0) begin
          we         = 1'b1;
          cnt_next   = cnt + 1'b1;
          done_next  = 1'b1;
          state_next = sol_pkg::ST_IDLE;
        end else begin
          re         = 1'b1;
          raddr      = sol_pkg::IDX_W'(j - 1'b1);
          state_next = sol_pkg::ST_INS_CMP;
        end
      end
      sol_pkg::ST_INS_CMP: begin
        // shift a larger entry up one slot; equal offsets stay below
        we = 1'b1;
        if (rdata.offset > key) begin
          wdata      = rdata;
          j_next     = j - 1'b1;
          state_next = sol_pkg::ST_INS_RD;
        end else begin
          cnt_next   = cnt + 1'b1;
          done_next  = 1'b1;
          state_next = sol_pkg::ST_IDLE;
        end
      end
      sol_pkg::ST_SRCH_RD: begin
        if (lo == hi) begin
          // search converged on the first position not below key
          if (req_q == sol_pkg::REQ_FIND) begin
            if (lo < cnt && hit.offset == key) begin
              found_next = 1'b1;
              id_next    = hit.id;
            end
            done_next  = 1'b1;
            state_next = sol_pkg::ST_IDLE;
          end else if (!second) begin
            if (lo < cnt) begin
              b_pos_next  = lo;
              second_next = 1'b1;
              lo_next     = '0;
              hi_next     = cnt;
              key_next    = end_key;
            end else begin
              done_next  = 1'b1;
              state_next = sol_pkg::ST_IDLE;
            end
          end else begin
            if (lo > b_pos) begin
              match_next = sol_pkg::CNT_W'(lo - b_pos);
            end
            done_next  = 1'b1;
            state_next = sol_pkg::ST_IDLE;
          end
        end else begin
          re         = 1'b1;
          state_next = sol_pkg::ST_SRCH_CMP;
        end
      end
      sol_pkg::ST_SRCH_CMP: begin
        // narrow the window; remember the entry at the upper bound
        if (rdata.offset < key) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next  = mid;
          hit_next = rdata;
        end
        state_next = sol_pkg::ST_SRCH_RD;
      end
      default: begin
        state_next = sol_pkg::ST_IDLE;
      end
    endcase
  end

  // the strobe comes only after the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == sol_pkg::ST_IDLE)
    else $error("result strobe while request still in progress");

  // the table never holds more entries than it has slots
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= sol_pkg::POS_W'(sol_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  // a load grows the table by one entry at most
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    cnt != $past(cnt) |-> cnt == $past(cnt) + 1'b1 && done)
    else $error("entry count changed without a completed load");

  // a hit always reports status ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == sol_pkg::STAT_OK)
    else $error("find hit with error status");

endmodule
